// File: hw/rtl/pae_pkg.sv
// Package for the piecewise amplitude envelope: widths, constants, codes and types.
// Used by pae_div and piecewise_amplitude_envelope; depends on nothing.
package pae_pkg;

   localparam int MAX_POINTS_DEFAULT  = 16;
   localparam int SAMPLE_BITS_DEFAULT = 24;

   localparam int TIME_BITS  = 26;
   localparam int LEVEL_BITS = 18;
   localparam int CURVE_BITS = 3;
   localparam int RATE_BITS  = 18;
   localparam int FRAME_BITS = 24;
   localparam int US_BITS    = 20;
   localparam int TUS_BITS   = FRAME_BITS + US_BITS;
   localparam int FRAC_BITS  = 16;
   localparam int ALPHA_BITS = FRAC_BITS + 1;
   localparam int SQ_BITS    = 2 * ALPHA_BITS;
   localparam int CSR_DATA_BITS  = 18;
   localparam int COUNT_IN_BITS  = 5;
   localparam int INDEX_IN_BITS  = 4;

   localparam logic [RATE_BITS-1:0]  RATE_RESET    = 18'd48000;
   localparam logic [FRAME_BITS-1:0] FRAME_MAX     = '1;
   localparam logic [US_BITS-1:0]    US_PER_SECOND = 20'd1000000;
   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE     = 17'd65536;
   localparam logic [ALPHA_BITS:0]   SCURVE_K      = 18'd196608;

   typedef enum logic [0:0] {
      CSR_POINT_COUNT = 1'b0,
      CSR_SAMPLE_RATE = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_SAMPLE = 1'b0,
      REQ_LOAD   = 1'b1
   } req_kind_type;

   typedef enum logic [CURVE_BITS-1:0] {
      CURVE_LINEAR = 3'd0,
      CURVE_EXP    = 3'd1,
      CURVE_LOG    = 3'd2,
      CURVE_STEP   = 3'd3,
      CURVE_SCURVE = 3'd4
   } curve_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]         time_us;
      logic signed [LEVEL_BITS-1:0] level;
      logic [CURVE_BITS-1:0]        curve;
   } point_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_P0, ST_P0C, ST_SCAN, ST_SCANM, ST_SCANC, ST_SEG, ST_LAST,
      ST_RA, ST_RB, ST_RB2, ST_CMP, ST_DIV, ST_SQ, ST_SHP, ST_LVL, ST_MUL,
      ST_SAT, ST_DONE
   } state_type;

endpackage

// File: hw/rtl/pae_div.sv
// Iterative restoring divider for the segment fraction, one quotient bit per cycle.
// Depends on pae_pkg.
module pae_div
   import pae_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TUS_BITS-1:0]  num,
   input  logic [TUS_BITS-1:0]  den,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [TUS_BITS:0]    rem_ff;
   logic [TUS_BITS-1:0]  den_ff;
   logic [FRAC_BITS-1:0] q_ff;
   logic [TUS_BITS:0]    rem_shift;
   logic                 take;

   assign rem_shift = {rem_ff[TUS_BITS-1:0], 1'b0};
   assign take      = rem_shift >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= take ? rem_shift - {1'b0, den_ff} : rem_shift;
         q_ff   <= {q_ff[FRAC_BITS-2:0], take};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// File: hw/rtl/piecewise_amplitude_envelope.sv
// Piecewise amplitude envelope: top level with breakpoint memory and sequencer.
// Depends on pae_pkg and pae_div.
//
// A load transfer passes from idle straight to the done state, as does a sample transfer
// in pass-through. Any other sample transfer scans the breakpoints and takes longer for each
// one the segment cursor advances over; the 16-iteration fraction divider and the single read
// port of the breakpoint memory set its duration. A result may wait in the output register
// while the next transfer is taken.
module piecewise_amplitude_envelope
   import pae_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_restart,
   input  logic [INDEX_IN_BITS-1:0]      req_point_index,
   input  logic [TIME_BITS-1:0]          req_point_time,
   input  logic signed [LEVEL_BITS-1:0]  req_point_level,
   input  logic [CURVE_BITS-1:0]         req_point_curve,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int MW = SAMPLE_BITS + LEVEL_BITS;
   localparam logic signed [MW-1:0] ROUND_HALF = MW'(32768);
   localparam logic signed [SAMPLE_BITS+1:0] SAT_MAX = $signed({3'b000, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [SAMPLE_BITS+1:0] SAT_MIN = $signed({3'b111, {(SAMPLE_BITS-1){1'b0}}});

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   point_type     wr_data;

   state_type state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [RATE_BITS-1:0]  rate_ff, rate_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [AW-1:0]         cursor_ff, cursor_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] result_ff, result_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_error_ff, rsp_error_in;
   logic [TUS_BITS-1:0]           t_ff, t_in;
   logic [TUS_BITS-1:0]           prod_ff, prod_in;
   logic [TUS_BITS-1:0]           num_ff, num_in;
   logic [TIME_BITS-1:0]          ta_ff, ta_in;
   logic [TIME_BITS-1:0]          diff_ff, diff_in;
   logic signed [LEVEL_BITS-1:0]  la_ff, la_in;
   logic signed [LEVEL_BITS-1:0]  lb_ff, lb_in;
   logic signed [LEVEL_BITS-1:0]  lvl0_ff, lvl0_in;
   logic signed [LEVEL_BITS-1:0]  level_ff, level_in;
   logic [CURVE_BITS-1:0]         curve_ff, curve_in;
   logic                          before_ff, before_in;
   logic [ALPHA_BITS-1:0]         alpha_ff, alpha_in;
   logic [SQ_BITS-1:0]            sq_ff, sq_in;
   logic [ALPHA_BITS-1:0]         sh_ff, sh_in;
   logic signed [MW-1:0]          mul_ff, mul_in;

   logic                  req_fire;
   logic                  div_start;
   logic                  div_done;
   logic [FRAC_BITS-1:0]  div_quot;
   logic [CW-1:0]         last;
   logic [FRAME_BITS-1:0] frame_sel;
   logic [ALPHA_BITS-1:0] sq_arg;
   logic [ALPHA_BITS:0]   scurve_k2;
   logic [SQ_BITS+ALPHA_BITS:0] scurve_prod;
   logic signed [LEVEL_BITS:0]  lvl_diff;
   logic signed [LEVEL_BITS+ALPHA_BITS+2:0] lvl_acc;
   logic signed [MW-1:0]        mul_rnd;
   logic signed [SAMPLE_BITS+1:0] mul_shift;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign last      = count_ff - 1'b1;
   assign frame_sel = req_restart ? '0 : frame_ff;

   assign sq_arg      = (curve_ff == CURVE_EXP) ? ALPHA_ONE - alpha_ff : alpha_ff;
   assign scurve_k2   = SCURVE_K - {alpha_ff, 1'b0};
   assign scurve_prod = sq_ff * scurve_k2;
   assign lvl_diff    = (LEVEL_BITS+1)'(lb_ff) - (LEVEL_BITS+1)'(la_ff);
   assign lvl_acc     = lvl_diff * $signed({2'b00, sh_ff})
                      + ($signed((LEVEL_BITS+ALPHA_BITS+3)'(la_ff)) <<< FRAC_BITS)
                      + (LEVEL_BITS+ALPHA_BITS+3)'(32768);
   assign mul_rnd     = mul_ff + ROUND_HALF;
   assign mul_shift   = mul_rnd[MW-1:FRAC_BITS];

   pae_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (prod_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rate_in       = rate_ff;
      frame_in      = frame_ff;
      cursor_in     = cursor_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      sample_in     = sample_ff;
      result_in     = result_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_error_in  = rsp_error_ff;
      t_in          = t_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      ta_in         = ta_ff;
      diff_in       = diff_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      lvl0_in       = lvl0_ff;
      level_in      = level_ff;
      curve_in      = curve_ff;
      before_in     = before_ff;
      alpha_in      = alpha_ff;
      sq_in         = sq_ff;
      sh_in         = sh_ff;
      mul_in        = mul_ff;
      rd_addr       = '0;
      mem_we        = 1'b0;
      wr_addr       = AW'(req_point_index);
      wr_data       = '{time_us: req_point_time, level: req_point_level,
                        curve: req_point_curve};
      div_start     = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POINT_COUNT: begin
               if (32'(csr_data[COUNT_IN_BITS-1:0]) > MAX_POINTS) begin
                  count_in = CW'(MAX_POINTS);
               end else begin
                  count_in = CW'(csr_data[COUNT_IN_BITS-1:0]);
               end
            end
            CSR_SAMPLE_RATE: begin
               rate_in = csr_data[RATE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_LOAD) begin
                  err_in = (req_point_index == '0) ? 1'b0 : err_ff;
                  if (req_point_curve > CURVE_SCURVE) begin
                     err_in = 1'b1;
                  end else if (32'(req_point_index) < MAX_POINTS) begin
                     mem_we = 1'b1;
                  end
                  result_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  sample_in = req_sample_in;
                  frame_in  = (frame_sel == FRAME_MAX) ? FRAME_MAX : frame_sel + 1'b1;
                  t_in      = frame_sel * US_PER_SECOND;
                  if (req_restart) begin
                     cursor_in = '0;
                  end
                  if (count_ff == '0 || rate_ff == '0) begin
                     result_in = req_sample_in;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_P0;
                  end
               end
            end
         end
         ST_P0: begin
            lvl0_in  = rd_data_ff.level;
            prod_in  = rd_data_ff.time_us * rate_ff;
            state_in = ST_P0C;
         end
         ST_P0C: begin
            before_in = (t_ff <= prod_ff);
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr = cursor_ff + 1'b1;
            if (CW'(cursor_ff) < last) begin
               state_in = ST_SCANM;
            end else begin
               state_in = ST_SEG;
            end
         end
         ST_SCANM: begin
            prod_in  = rd_data_ff.time_us * rate_ff;
            state_in = ST_SCANC;
         end
         ST_SCANC: begin
            if (t_ff >= prod_ff) begin
               cursor_in = cursor_ff + 1'b1;
               state_in  = ST_SCAN;
            end else begin
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (before_ff) begin
               level_in = lvl0_ff;
               state_in = ST_MUL;
            end else if (CW'(cursor_ff) >= last) begin
               rd_addr  = AW'(last);
               state_in = ST_LAST;
            end else begin
               rd_addr  = cursor_ff;
               state_in = ST_RA;
            end
         end
         ST_LAST: begin
            level_in = rd_data_ff.level;
            state_in = ST_MUL;
         end
         ST_RA: begin
            rd_addr  = cursor_ff + 1'b1;
            ta_in    = rd_data_ff.time_us;
            la_in    = rd_data_ff.level;
            curve_in = rd_data_ff.curve;
            state_in = ST_RB;
         end
         ST_RB: begin
            lb_in = rd_data_ff.level;
            if (rd_data_ff.time_us <= ta_ff) begin
               level_in = rd_data_ff.level;
               state_in = ST_MUL;
            end else begin
               prod_in  = ta_ff * rate_ff;
               diff_in  = rd_data_ff.time_us - ta_ff;
               state_in = ST_RB2;
            end
         end
         ST_RB2: begin
            num_in   = (t_ff > prod_ff) ? t_ff - prod_ff : '0;
            prod_in  = diff_ff * rate_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (num_ff >= prod_ff) begin
               alpha_in = ALPHA_ONE;
               state_in = ST_SQ;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               alpha_in = {1'b0, div_quot};
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in    = sq_arg * sq_arg;
            state_in = ST_SHP;
         end
         ST_SHP: begin
            case (curve_ff)
               CURVE_EXP:    sh_in = ALPHA_ONE - sq_ff[SQ_BITS-2:FRAC_BITS];
               CURVE_LOG:    sh_in = sq_ff[SQ_BITS-2:FRAC_BITS];
               CURVE_STEP:   sh_in = '0;
               CURVE_SCURVE: sh_in = scurve_prod[2*FRAC_BITS+ALPHA_BITS-1:2*FRAC_BITS];
               default:      sh_in = alpha_ff;
            endcase
            state_in = ST_LVL;
         end
         ST_LVL: begin
            level_in = lvl_acc[FRAC_BITS+LEVEL_BITS-1:FRAC_BITS];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_in   = sample_ff * level_ff;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (mul_shift > SAT_MAX) begin
               result_in = SAT_MAX[SAMPLE_BITS-1:0];
            end else if (mul_shift < SAT_MIN) begin
               result_in = SAT_MIN[SAMPLE_BITS-1:0];
            end else begin
               result_in = mul_shift[SAMPLE_BITS-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = result_ff;
               rsp_error_in  = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rate_ff      <= RATE_RESET;
         frame_ff     <= '0;
         cursor_ff    <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rate_ff      <= rate_in;
         frame_ff     <= frame_in;
         cursor_ff    <= cursor_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      result_ff     <= result_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_error_ff  <= rsp_error_in;
      t_ff          <= t_in;
      prod_ff       <= prod_in;
      num_ff        <= num_in;
      ta_ff         <= ta_in;
      diff_ff       <= diff_in;
      la_ff         <= la_in;
      lb_ff         <= lb_in;
      lvl0_ff       <= lvl0_in;
      level_ff      <= level_in;
      curve_ff      <= curve_in;
      before_ff     <= before_in;
      alpha_ff      <= alpha_in;
      sq_ff         <= sq_in;
      sh_ff         <= sh_in;
      mul_ff        <= mul_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_error      = rsp_error_ff;

`ifndef SYNTHESIS
   a_cursor_forward: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_type == REQ_SAMPLE && req_restart) |=> cursor_ff >= $past(cursor_ff))
      else $error("segment cursor moved backward without a restart");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) < MAX_POINTS)
      else $error("segment cursor beyond the breakpoint memory");

   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type == REQ_SAMPLE && !req_restart && frame_ff != FRAME_MAX)
      |=> frame_ff == $past(frame_ff) + 1'b1)
      else $error("frame counter did not advance by one");
`endif

endmodule
